// ===== rtl/wps_pkg.sv =====
// wps_pkg: shared widths, defaults, controller states and the
// command/status structs of the waveform pedestal subtract block
// no dependencies
package wps_pkg;

  localparam int DATA_W  = 16;
  localparam int CFG_W   = 7;
  localparam int PED_W   = 24;
  localparam int SD_W    = 24;
  localparam int SUM_W   = 40;
  localparam int PED_FRAC = 8;

  localparam int DEF_MAX_PED   = 64;
  localparam int DEF_MAX_TRACE = 65536;
  localparam logic [CFG_W-1:0] DEF_PED_COUNT = 7'd10;

  // reciprocal of n as ceil(2^(RECIP_SHIFT-1)/n), scaled for a divide by 2n
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_MUL,
    ST_SAT,
    ST_PED_GO,
    ST_PED_WAIT,
    ST_SQ,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic prep;
    logic mul;
    logic sat;
    logic ped_go;
    logic ped_take;
    logic sq;
    logic var_go;
    logic var_take;
    logic sd_take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic go_replay;
    logic go_corr;
    logic raw;
    logic final_item;
    logic more;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/wps_if.sv =====
// wps_samp_if / wps_res_if: valid-ready channels for samples and results
// depends on wps_pkg
interface wps_samp_if;
  logic                                valid;
  logic                                ready;
  logic signed [wps_pkg::DATA_W-1:0]   sample;
  logic                                is_last;
  modport source (output valid, sample, is_last, input ready);
  modport sink (input valid, sample, is_last, output ready);
endinterface

interface wps_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [wps_pkg::DATA_W-1:0]   corrected_sample;
  logic signed [wps_pkg::PED_W-1:0]    pedestal_q8;
  logic        [wps_pkg::SD_W-1:0]     stdev_q8;
  logic signed [wps_pkg::SUM_W-1:0]    trace_sum;
  logic                                too_short;
  logic                                is_final;
  modport source (output valid, corrected_sample, pedestal_q8, stdev_q8, trace_sum,
                  too_short, is_final, input ready);
  modport sink (input valid, corrected_sample, pedestal_q8, stdev_q8, trace_sum,
                too_short, is_final, output ready);
endinterface

// ===== rtl/waveform_pedestal_subtract.sv =====
// waveform_pedestal_subtract: top level, wires wps_ctrl to wps_dp over wps_pkg and wps_if
// held samples: one transfer per cycle, no result until the nth; its replay runs read, prep,
// multiply, saturate and emit per result, the raw replay of a too-short trace read and emit
// later samples: each runs prep, multiply, saturate and emit before the next is accepted
// trace end adds a serial divider for mean and variance, then a square root
// synchronous reset clears the sequencer, sums and output valid; count resets to 10
module waveform_pedestal_subtract #(
  parameter int MAX_PEDESTAL_SAMPLES = wps_pkg::DEF_MAX_PED,
  parameter int MAX_TRACE_LENGTH     = wps_pkg::DEF_MAX_TRACE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [wps_pkg::CFG_W-1:0] cfg_data,
  wps_samp_if.sink                  samp,
  wps_res_if.source                 res
);

  wps_pkg::cmd_t    cmd;
  wps_pkg::status_t st;
  logic             in_ready;

  // input transfer happens only while the sequencer is idle
  assign samp.ready = in_ready;

  wps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samp.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath owns the output register; a waiting result holds the sequencer in emit,
  // so input stalls until that result transfer
  wps_dp #(
    .MAX_PED   (MAX_PEDESTAL_SAMPLES),
    .MAX_TRACE (MAX_TRACE_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sample    (samp.sample),
    .is_last   (samp.is_last),
    .out_ready (res.ready),
    .cmd       (cmd),
    .st        (st),
    .out_valid (res.valid),
    .o_corr    (res.corrected_sample),
    .o_ped     (res.pedestal_q8),
    .o_sd      (res.stdev_q8),
    .o_sum     (res.trace_sum),
    .o_short   (res.too_short),
    .o_final   (res.is_final)
  );

endmodule

// ===== rtl/wps_div.sv =====
// wps_div: restoring divider, one quotient bit per cycle
// no package dependencies
module wps_div #(
  parameter int DVW = 60,
  parameter int DRW = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DRW-1:0] divisor,
  output logic [DVW-1:0] quotient,
  output logic           done
);

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] dq;
  logic [DRW-1:0] rem;
  logic [DRW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DRW:0]   trial;
  logic           ge;

  assign trial    = {rem, dq[DVW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(DVW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DRW'(trial - {1'b0, dvs}) : DRW'(trial);
      dq  <= {dq[DVW-2:0], ge};
    end
  end

endmodule

// ===== rtl/wps_sqrt.sv =====
// wps_sqrt: integer square root (floor), two radicand bits per cycle
// no package dependencies
module wps_sqrt #(
  parameter int W = 60
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         radicand,
  output logic [(W+1)/2-1:0]   root,
  output logic                 done
);

  localparam int SP = (W - 1) - ((W - 1) % 2);

  logic [W-1:0] x;
  logic [W-1:0] r;
  logic [W-1:0] bt;
  logic         busy;
  logic [W-1:0] trial;

  assign trial = r + bt;
  assign root  = r[(W+1)/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (bt >> 2) == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x  <= radicand;
      r  <= '0;
      bt <= W'(1) << SP;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bt;
      end else begin
        r <= r >> 1;
      end
      bt <= bt >> 2;
    end
  end

endmodule

// ===== rtl/wps_ctrl.sv =====
// wps_ctrl: sequencer for accept, replay, correction, statistics and emit
// depends on wps_pkg
module wps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wps_pkg::status_t st,
  output wps_pkg::cmd_t    cmd
);

  wps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      wps_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (st.go_replay) begin
            state_next = wps_pkg::ST_READ;
          end else if (st.go_corr) begin
            state_next = wps_pkg::ST_PREP;
          end
        end
      end
      wps_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = st.raw ? wps_pkg::ST_EMIT : wps_pkg::ST_PREP;
      end
      wps_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = wps_pkg::ST_MUL;
      end
      wps_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = wps_pkg::ST_SAT;
      end
      wps_pkg::ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = st.final_item ? wps_pkg::ST_PED_GO : wps_pkg::ST_EMIT;
      end
      wps_pkg::ST_PED_GO: begin
        cmd.ped_go = 1'b1;
        state_next = wps_pkg::ST_PED_WAIT;
      end
      wps_pkg::ST_PED_WAIT: begin
        if (st.div_done) begin
          cmd.ped_take = 1'b1;
          state_next   = wps_pkg::ST_SQ;
        end
      end
      wps_pkg::ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = wps_pkg::ST_VAR_GO;
      end
      wps_pkg::ST_VAR_GO: begin
        cmd.var_go = 1'b1;
        state_next = wps_pkg::ST_VAR_WAIT;
      end
      wps_pkg::ST_VAR_WAIT: begin
        if (st.div_done) begin
          cmd.var_take = 1'b1;
          state_next   = wps_pkg::ST_SQRT_WAIT;
        end
      end
      wps_pkg::ST_SQRT_WAIT: begin
        if (st.sqrt_done) begin
          cmd.sd_take = 1'b1;
          state_next  = wps_pkg::ST_EMIT;
        end
      end
      wps_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (!st.final_item && st.more) begin
            state_next = wps_pkg::ST_READ;
          end else begin
            state_next = wps_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = wps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wps_dp.sv =====
// wps_dp: sample store, running sums, corrector, statistics and output register
// depends on wps_pkg, wps_div, wps_sqrt
module wps_dp #(
  parameter int MAX_PED   = wps_pkg::DEF_MAX_PED,
  parameter int MAX_TRACE = wps_pkg::DEF_MAX_TRACE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wps_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [wps_pkg::DATA_W-1:0]   sample,
  input  logic                                is_last,
  input  logic                                out_ready,
  input  wps_pkg::cmd_t                       cmd,
  output wps_pkg::status_t                    st,
  output logic                                out_valid,
  output logic signed [wps_pkg::DATA_W-1:0]   o_corr,
  output logic signed [wps_pkg::PED_W-1:0]    o_ped,
  output logic        [wps_pkg::SD_W-1:0]     o_sd,
  output logic signed [wps_pkg::SUM_W-1:0]    o_sum,
  output logic                                o_short,
  output logic                                o_final
);

  localparam int DW_   = wps_pkg::DATA_W;
  localparam int NW    = $clog2(MAX_PED + 1);
  localparam int AW    = $clog2(MAX_PED);
  localparam int IW    = $clog2(MAX_TRACE + 1);
  localparam int SW    = DW_ + AW;
  localparam int SQW   = 2 * DW_ - 1 + AW;
  localparam int PW    = DW_ + NW + 2;
  localparam int XW    = DW_ + NW + 1;
  localparam int QW    = XW - 1;
  localparam int MW    = XW + wps_pkg::RECIP_W;
  localparam int DEVW  = NW + SQW;
  localparam int DVW   = DEVW + 2 * wps_pkg::PED_FRAC;
  localparam int DRW   = 2 * NW - 1;
  localparam int RTW   = (DVW + 1) / 2;
  localparam int SUMW  = wps_pkg::SUM_W;

  localparam logic signed [QW:0] C_MAX = (QW+1)'(2 ** (DW_ - 1) - 1);
  localparam logic signed [QW:0] C_MIN = -C_MAX - (QW+1)'(1);

  // reciprocal table, one entry per pedestal count
  logic [wps_pkg::RECIP_W-1:0] recip [0:MAX_PED];
  for (genvar g = 0; g <= MAX_PED; g++) begin : g_recip
    localparam longint unsigned Den = (g < 2) ? 1 : g;
    localparam longint unsigned Rv  =
        (g < 2) ? 0 : ((64'd1 << (wps_pkg::RECIP_SHIFT - 1)) + Den - 1) / Den;
    assign recip[g] = wps_pkg::RECIP_W'(Rv);
  end

  logic signed [DW_-1:0] mem [0:MAX_PED-1];

  logic [wps_pkg::CFG_W-1:0] ped_count;
  logic [NW-1:0]             cnt_n;
  logic [IW-1:0]             idx;
  logic signed [SW-1:0]      sum;
  logic [SQW-1:0]            sq;
  logic signed [SUMW-1:0]    csum;
  logic                      rep_r;
  logic                      raw_r;
  logic [AW-1:0]             k;

  logic signed [DW_-1:0]     in_s;
  logic                      last_r;
  logic signed [DW_-1:0]     rd_data;
  logic [XW-1:0]             x_r;
  logic                      neg_r;
  logic [QW-1:0]             q_r;
  logic signed [DW_-1:0]     c_r;
  logic signed [wps_pkg::PED_W-1:0] ped_r;
  logic [DEVW-1:0]           s2_r;
  logic [DEVW-1:0]           nq_r;
  logic [DRW-1:0]            nn_r;
  logic [wps_pkg::SD_W-1:0]  sd_r;

  // accept-time decisions
  logic [NW-1:0]  eff_cfg;
  logic [NW-1:0]  eff_n;
  logic           hold;
  logic           fill_done;

  always_comb begin
    if (ped_count < wps_pkg::CFG_W'(2)) begin
      eff_cfg = NW'(2);
    end else if (ped_count > wps_pkg::CFG_W'(MAX_PED)) begin
      eff_cfg = NW'(MAX_PED);
    end else begin
      eff_cfg = NW'(ped_count);
    end
  end

  assign eff_n     = (idx == '0) ? eff_cfg : cnt_n;
  assign hold      = idx < IW'(eff_n);
  assign fill_done = (idx + IW'(1)) == IW'(eff_n);

  // end of replay and final-result detection
  logic k_end;
  logic fin;
  assign k_end = raw_r ? (IW'(k) == idx - IW'(1)) : (NW'(k) == cnt_n - NW'(1));
  assign fin   = raw_r ? k_end : (rep_r ? (k_end && last_r) : last_r);

  // corrector arithmetic
  logic signed [DW_-1:0] opnd;
  logic signed [PW-1:0]  prod_n;
  logic signed [PW-1:0]  diff;
  logic [PW-1:0]         mag;
  logic [MW-1:0]         p2;
  logic signed [QW:0]    sv;
  logic signed [DW_-1:0] c_next;
  logic signed [SUMW:0]  t_sum;
  logic signed [SUMW-1:0] csum_next;

  assign opnd   = rep_r ? rd_data : in_s;
  assign prod_n = PW'(opnd) * $signed(PW'({1'b0, cnt_n}));
  assign diff   = prod_n - PW'(sum);
  assign mag    = diff[PW-1] ? PW'(-diff) : PW'(diff);
  assign p2     = MW'(x_r) * MW'(recip[cnt_n]);
  assign sv     = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    if (sv > C_MAX) begin
      c_next = DW_'(C_MAX);
    end else if (sv < C_MIN) begin
      c_next = DW_'(C_MIN);
    end else begin
      c_next = DW_'(sv);
    end
  end

  assign t_sum = (SUMW+1)'(csum) + (SUMW+1)'(c_next);
  always_comb begin
    if (t_sum[SUMW] != t_sum[SUMW-1]) begin
      csum_next = t_sum[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
    end else begin
      csum_next = SUMW'(t_sum);
    end
  end

  // statistics operands
  logic [SW-1:0]  abs_sum;
  logic [DVW-1:0] ped_dvd;
  logic [DEVW-1:0] dev;
  logic [DVW-1:0] var_dvd;
  logic           div_start;
  logic [DVW-1:0] div_dvd;
  logic [DRW-1:0] div_dvs;
  logic [DVW-1:0] div_q;
  logic           div_done;
  logic [RTW-1:0] root;
  logic           sqrt_done;
  logic [wps_pkg::PED_W-1:0] pq;

  assign abs_sum = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign ped_dvd = (DVW'(abs_sum) << (wps_pkg::PED_FRAC + 1)) + DVW'(cnt_n);
  assign dev     = (nq_r >= s2_r) ? nq_r - s2_r : '0;
  assign var_dvd = DVW'(dev) << (2 * wps_pkg::PED_FRAC);
  assign div_start = cmd.ped_go | cmd.var_go;
  assign div_dvd   = cmd.ped_go ? ped_dvd : var_dvd;
  assign div_dvs   = cmd.ped_go ? DRW'({cnt_n, 1'b0}) : nn_r;
  assign pq        = div_q[wps_pkg::PED_W-1:0];

  wps_div #(.DVW(DVW), .DRW(DRW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  wps_sqrt #(.W(DVW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.var_take),
    .radicand (div_q),
    .root     (root),
    .done     (sqrt_done)
  );

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    st            = '0;
    st.go_replay  = hold && (fill_done || is_last);
    st.go_corr    = !hold;
    st.raw        = raw_r;
    st.final_item = fin;
    st.more       = (rep_r || raw_r) && !k_end;
    st.div_done   = div_done;
    st.sqrt_done  = sqrt_done;
    st.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ped_count <= wps_pkg::DEF_PED_COUNT;
      cnt_n     <= NW'(2);
      idx       <= '0;
      sum       <= '0;
      sq        <= '0;
      csum      <= '0;
      rep_r     <= 1'b0;
      raw_r     <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ped_count <= cfg_data;
      end
      if (cmd.accept) begin
        if (idx == '0) begin
          cnt_n <= eff_cfg;
        end
        if (hold) begin
          sum   <= sum + SW'(sample);
          sq    <= sq + SQW'(unsigned'(32'(sample * sample)));
          idx   <= idx + IW'(1);
          k     <= '0;
          rep_r <= fill_done;
          raw_r <= !fill_done && is_last;
        end else if (idx != IW'(MAX_TRACE)) begin
          idx <= idx + IW'(1);
        end
      end
      if (cmd.sat) begin
        csum <= csum_next;
      end
      if (cmd.emit) begin
        if (fin) begin
          idx   <= '0;
          sum   <= '0;
          sq    <= '0;
          csum  <= '0;
          rep_r <= 1'b0;
          raw_r <= 1'b0;
        end else if (st.more) begin
          k <= k + AW'(1);
        end else begin
          rep_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.accept && hold) begin
      mem[idx[AW-1:0]] <= sample;
    end
    if (cmd.rd) begin
      rd_data <= mem[k];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_s   <= sample;
      last_r <= is_last;
    end
    if (cmd.prep) begin
      x_r   <= XW'((mag << 1) + PW'(cnt_n));
      neg_r <= diff[PW-1];
    end
    if (cmd.mul) begin
      q_r <= p2[wps_pkg::RECIP_SHIFT +: QW];
    end
    if (cmd.sat) begin
      c_r <= c_next;
    end
    if (cmd.ped_take) begin
      ped_r <= sum[SW-1] ? -$signed(pq) : $signed(pq);
    end
    if (cmd.sq) begin
      s2_r <= DEVW'(unsigned'((2*SW)'(sum) * (2*SW)'(sum)));
      nq_r <= DEVW'(cnt_n) * DEVW'(sq);
      nn_r <= DRW'(cnt_n) * DRW'(cnt_n - NW'(1));
    end
    if (cmd.sd_take) begin
      sd_r <= (root > RTW'({wps_pkg::SD_W{1'b1}})) ? {wps_pkg::SD_W{1'b1}}
                                                   : wps_pkg::SD_W'(root);
    end
    if (cmd.emit) begin
      o_corr  <= raw_r ? rd_data : c_r;
      o_ped   <= (fin && !raw_r) ? ped_r : '0;
      o_sd    <= (fin && !raw_r) ? sd_r : '0;
      o_sum   <= (fin && !raw_r) ? csum : '0;
      o_short <= raw_r;
      o_final <= fin;
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for waveform_pedestal_subtract
// drives sample transfers, predicts corrected results per trace, checks every result transfer
// depends on wps_pkg, wps_if and the rtl of the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PED   = 64;
  localparam int MAX_TRACE = 65536;
  localparam logic signed [wps_pkg::SUM_W-1:0] SUM_HI = 40'sh7F_FFFF_FFFF;
  localparam logic signed [wps_pkg::SUM_W-1:0] SUM_LO = 40'sh80_0000_0000;

  typedef struct packed {
    logic signed [wps_pkg::DATA_W-1:0] corrected_sample;
    logic signed [wps_pkg::PED_W-1:0]  pedestal_q8;
    logic        [wps_pkg::SD_W-1:0]   stdev_q8;
    logic signed [wps_pkg::SUM_W-1:0]  trace_sum;
    logic                              too_short;
    logic                              is_final;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [wps_pkg::CFG_W-1:0] cfg_data = '0;

  wps_samp_if samp ();
  wps_res_if  res ();

  waveform_pedestal_subtract u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .samp     (samp.sink),
    .res      (res.source)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state: our own copy of the register and the per-trace accumulators
  logic [wps_pkg::CFG_W-1:0]          count_reg;
  logic signed [wps_pkg::DATA_W-1:0]  held [MAX_PED];
  int unsigned                        seen;
  int unsigned                        n_lat;
  longint                             ped_sum;
  longint unsigned                    ped_sq;
  logic signed [wps_pkg::SUM_W-1:0]   corr_sum;

  result_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  bit sink_hold = 1'b0;     // long receiver hold-off, counted in its own process
  bit sink_steady = 1'b0;   // no random receiver gaps

  // divide rounded half away from zero, den > 0
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [wps_pkg::DATA_W-1:0] subtract_pedestal(longint s);
    longint v;
    v = round_div(s * longint'(n_lat) - ped_sum, n_lat);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[wps_pkg::DATA_W-1:0];
  endfunction

  function automatic void accumulate(logic signed [wps_pkg::DATA_W-1:0] c);
    longint t;
    t = longint'(corr_sum) + longint'(c);
    if (t > longint'(SUM_HI)) t = longint'(SUM_HI);
    if (t < longint'(SUM_LO)) t = longint'(SUM_LO);
    corr_sum = t[wps_pkg::SUM_W-1:0];
  endfunction

  function automatic void clear_trace();
    seen = 0;
    ped_sum = 0;
    ped_sq = 0;
    corr_sum = '0;
    n_lat = 2;
  endfunction

  function automatic result_t plain(logic signed [wps_pkg::DATA_W-1:0] c, logic ts);
    result_t r;
    r = '0;
    r.corrected_sample = c;
    r.too_short = ts;
    return r;
  endfunction

  // append one expectation at the tail of the queue
  function automatic void queue_result(result_t r);
    expected_results = {expected_results, r};
  endfunction

  // pedestal subtraction predictor: queue every result one accepted sample causes
  function automatic void predict_sample(logic signed [wps_pkg::DATA_W-1:0] s, logic last);
    logic signed [wps_pkg::DATA_W-1:0] c;
    result_t r;
    longint ped, s2, nq, dev;
    longint unsigned sd;
    if (seen == 0) begin
      n_lat = (count_reg < 2) ? 2 : (count_reg > MAX_PED) ? MAX_PED : count_reg;
    end
    if (seen < n_lat) begin
      held[seen] = s;
      ped_sum += s;
      ped_sq += longint'(s) * longint'(s);
      seen++;
      if (seen < n_lat) begin
        if (!last) return;
        // short trace: everything passes raw
        for (int k = 0; k < seen; k++) begin
          r = plain(held[k], 1'b1);
          r.is_final = (k == seen - 1);
          queue_result(r);
        end
        clear_trace();
        return;
      end
      // nth sample: replay the held pedestal samples corrected
      for (int k = 0; k < n_lat; k++) begin
        c = subtract_pedestal(held[k]);
        accumulate(c);
        queue_result(plain(c, 1'b0));
      end
    end else begin
      c = subtract_pedestal(s);
      accumulate(c);
      if (seen < MAX_TRACE) seen++;
      queue_result(plain(c, 1'b0));
    end
    if (last) begin
      r = expected_results.pop_back();
      ped = round_div(ped_sum * 256, n_lat);
      s2 = ped_sum * ped_sum;
      nq = longint'(n_lat) * longint'(ped_sq);
      dev = (nq >= s2) ? nq - s2 : 0;
      sd = int_sqrt((longint'(dev) << 16) / (n_lat * (n_lat - 1)));
      if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;
      r.pedestal_q8 = ped[wps_pkg::PED_W-1:0];
      r.stdev_q8 = sd[wps_pkg::SD_W-1:0];
      r.trace_sum = corr_sum;
      r.is_final = 1'b1;
      queue_result(r);
      clear_trace();
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // initial values of the channel signals the bench drives
  initial begin
    samp.valid <= 1'b0;
    samp.sample <= '0;
    samp.is_last <= 1'b0;
    res.ready <= 1'b0;
  end

  // receiver side: random gaps, or a long counted hold-off
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        res.ready <= 1'b0;
        for (int k = 0; k < 600; k++) @(posedge clk);
        sink_hold = 1'b0;
      end
      gap = sink_steady ? 0 : ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 2);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (res.corrected_sample !== want.corrected_sample)
          report_mismatch("corrected_sample", res.corrected_sample, want.corrected_sample);
        if (res.pedestal_q8 !== want.pedestal_q8)
          report_mismatch("pedestal_q8", res.pedestal_q8, want.pedestal_q8);
        if (res.stdev_q8 !== want.stdev_q8)
          report_mismatch("stdev_q8", res.stdev_q8, want.stdev_q8);
        if (res.trace_sum !== want.trace_sum)
          report_mismatch("trace_sum", res.trace_sum, want.trace_sum);
        if (res.too_short !== want.too_short)
          report_mismatch("too_short", res.too_short, want.too_short);
        if (res.is_final !== want.is_final)
          report_mismatch("is_final", res.is_final, want.is_final);
      end
      results_seen++;
    end
  end

  bit sender_steady = 1'b0;

  // one sample transfer; the prediction happens at the accepting edge
  task automatic send_sample(logic signed [wps_pkg::DATA_W-1:0] s, logic last);
    int gap;
    gap = sender_steady ? 0 : ($urandom_range(0, 11) == 0) ? $urandom_range(5, 25)
                                                          : $urandom_range(0, 2);
    if (gap > 0) begin
      samp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samp.valid <= 1'b1;
    samp.sample <= s;
    samp.is_last <= last;
    @(posedge clk);
    while (!samp.ready) @(posedge clk);
    predict_sample(s, last);
  endtask

  task automatic lower_valid();
    samp.valid <= 1'b0;
    @(posedge clk);
  endtask

  // pause until every expected result has come, plus the trace-end latency
  task automatic drain();
    int waited;
    lower_valid();
    waited = 0;
    while (expected_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_count(logic [wps_pkg::CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = v;
  endtask

  function automatic logic signed [wps_pkg::DATA_W-1:0] rand_sample(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 200)) - 16'd100;
      default: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic send_trace(int len, int mode);
    for (int k = 0; k < len; k++) send_sample(rand_sample(mode), k == len - 1);
  endtask

  // extremes of the sample field, saturation and the default count
  task automatic test_extremes();
    send_sample(16'sh7FFF, 1'b0);
    for (int k = 0; k < 9; k++) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    drain();
  endtask

  // a trace shorter than the count, and a one-sample trace
  task automatic test_short_trace();
    send_sample(16'sh1234, 1'b0);
    send_sample(-16'sh0042, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    drain();
  endtask

  // out-of-range counts are clamped; trace ending exactly at the nth sample
  task automatic test_count_clamp();
    write_count(7'd0);
    send_trace(2, 0);
    send_trace(3, 1);
    drain();
    write_count(7'd127);
    send_trace(64, 1);
    drain();
    write_count(7'd1);
    send_trace(2, 2);
    drain();
  endtask

  // count written mid-trace only takes effect at the next trace
  task automatic test_midtrace_write();
    write_count(7'd4);
    send_sample(16'sh0010, 1'b0);
    send_sample(16'sh0020, 1'b0);
    lower_valid();
    write_count(7'd2);
    send_sample(16'sh0030, 1'b0);
    send_sample(16'sh0041, 1'b0);
    send_sample(16'sh0050, 1'b1);
    send_trace(3, 1);
    drain();
  endtask

  // long receiver hold-off while the sender keeps offering, then a steady stretch
  task automatic test_backpressure();
    write_count(7'd3);
    sink_hold = 1'b1;
    sender_steady = 1'b1;
    send_trace(30, 0);
    sender_steady = 1'b0;
    drain();
  endtask

  // random traces over several counts, mostly small, a few at the maximum
  task automatic test_random_traces();
    int items, len;
    logic [wps_pkg::CFG_W-1:0] counts [5] = '{7'd2, 7'd5, 7'd64, 7'd10, 7'd3};
    foreach (counts[i]) begin
      write_count(counts[i]);
      sink_steady = (i == 3);
      items = 0;
      while (items < 12) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, counts[i])
                                          : counts[i] + $urandom_range(0, 12);
        if (counts[i] == 64) len = $urandom_range(0, 3) == 0 ? 70 : 20;
        send_trace(len, $urandom_range(0, 2));
        items += len;
      end
      sink_steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    count_reg = wps_pkg::DEF_PED_COUNT;
    clear_trace();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_short_trace();
    test_count_clamp();
    test_midtrace_write();
    test_backpressure();
    test_random_traces();
    if (expected_results.size() != 0)
      report_mismatch("outstanding results", expected_results.size(), 0);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end
endmodule
